/* design/two_level_lru_cache_tags_prefetch_defines.svh */
// Assertion helpers shared by the tag directory design
`ifndef TWO_LEVEL_LRU_CACHE_TAGS_PREFETCH_DEFINES_SVH
`define TWO_LEVEL_LRU_CACHE_TAGS_PREFETCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlc check failed");
// next-cycle implication
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlc check failed");
`else
`define TLC_ASSERT_NOW(label, clk, rst, ante, cons)
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/tlc_pkg.sv */
package tlc_pkg;
   // default geometry limits
   localparam int ADDRESS_BITS_DEF = 48;
   localparam int L1_MAX_SETS_DEF  = 64;
   localparam int L1_MAX_WAYS_DEF  = 8;
   localparam int L2_MAX_SETS_DEF  = 256;
   localparam int L2_MAX_WAYS_DEF  = 8;

   // config field widths
   localparam int OFFSET_W  = 5;
   localparam int L1_SET_W  = 3;
   localparam int L2_SET_W  = 4;
   localparam int WAYS_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_L1_OFFSET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_L1_SETS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_L1_WAYS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_L2_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_L2_SETS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_L2_WAYS   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFETCH  = 3'd6;

   // register reset values
   localparam logic [OFFSET_W-1:0] L1_OFFSET_RST = 5'd6;
   localparam logic [L1_SET_W-1:0] L1_SETS_RST   = 3'd6;
   localparam logic [WAYS_W-1:0]   L1_WAYS_RST   = 2'd0;
   localparam logic [OFFSET_W-1:0] L2_OFFSET_RST = 5'd6;
   localparam logic [L2_SET_W-1:0] L2_SETS_RST   = 4'd8;
   localparam logic [WAYS_W-1:0]   L2_WAYS_RST   = 2'd2;
endpackage

/* design/tlc_dir.sv */
// One set-associative tag directory: each set is one memory row holding
// valid, recency rank and tag of every way. A lookup reads the row in the
// go cycle and writes it back updated next cycle on a miss or touch.
module tlc_dir import tlc_pkg::*; #(
   parameter int AB        = ADDRESS_BITS_DEF,
   parameter int MAX_SETS  = L1_MAX_SETS_DEF,
   parameter int MAX_WAYS  = L1_MAX_WAYS_DEF,
   parameter int SET_CFG_W = L1_SET_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 flush,
   input  logic                 go,
   input  logic                 touch,
   input  logic [AB-1:0]        address,
   input  logic [OFFSET_W-1:0]  offset_bits,
   input  logic [SET_CFG_W-1:0] set_bits,
   input  logic [WAYS_W-1:0]    ways_log2,
   output logic                 hit
);
   localparam int SETS_LOG2 = $clog2(MAX_SETS + 1) - 1;
   localparam int WAYS_LOG2 = $clog2(MAX_WAYS + 1) - 1;
   localparam int SI_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WI_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RK_W   = WI_W;
   localparam int OLD_W  = RK_W + 1;
   localparam int WC_W   = $clog2(MAX_WAYS + 1);
   localparam int ENT_W  = 1 + RK_W + AB;
   localparam int ROW_W  = MAX_WAYS * ENT_W;

   logic [ROW_W-1:0]  rows_ff [MAX_SETS];
   logic [MAX_SETS-1:0] rowv_ff;
   logic [ROW_W-1:0]  row_rd_ff;
   logic              rv_rd_ff;
   logic [SI_W-1:0]   set_ff;
   logic [AB-1:0]     tag_ff;
   logic              touch_ff;
   logic [WI_W-1:0]   wm1_ff;
   logic [OLD_W-1:0]  ways_ff;
   logic              phase_ff;

   logic [5:0]        sb_eff;
   logic [WAYS_W:0]   wl_eff;
   logic [WC_W-1:0]   ways_n;
   logic [AB-1:0]     sh;
   logic [SI_W:0]     set_one;
   logic [SI_W-1:0]   set_idx;
   logic [AB-1:0]     tag_in;

   // decode set and tag of the incoming lookup
   always_comb begin
      sb_eff  = (6'(set_bits) > 6'(SETS_LOG2)) ? 6'(SETS_LOG2) : 6'(set_bits);
      wl_eff  = ({1'b0, ways_log2} > (WAYS_W+1)'(WAYS_LOG2)) ?
                (WAYS_W+1)'(WAYS_LOG2) : {1'b0, ways_log2};
      ways_n  = WC_W'(1) << wl_eff;
      sh      = address >> offset_bits;
      set_one = (SI_W+1)'(1) << sb_eff;
      set_idx = sh[SI_W-1:0] & SI_W'(set_one - (SI_W+1)'(1));
      tag_in  = address >> (7'(offset_bits) + 7'(sb_eff));
   end

   // request registers and row read
   always_ff @(posedge clock) begin
      if (go) begin
         set_ff    <= set_idx;
         tag_ff    <= tag_in;
         touch_ff  <= touch;
         wm1_ff    <= WI_W'(ways_n - WC_W'(1));
         ways_ff   <= OLD_W'(ways_n);
         row_rd_ff <= rows_ff[set_idx];
         rv_rd_ff  <= rowv_ff[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= go;
      end
   end

   logic [MAX_WAYS-1:0] vld, act, match;
   logic [RK_W-1:0]     rk [MAX_WAYS];
   logic [AB-1:0]       tg [MAX_WAYS];
   logic                hit_any, emp_found, upd;
   logic [WI_W-1:0]     hit_w, emp_w, vic_w, u_w, home, w_i;
   logic [OLD_W-1:0]    old;
   logic [ROW_W-1:0]    new_row;
   logic [RK_W-1:0]     nrk;
   logic                nvl;
   logic [AB-1:0]       ntg;

   // hit search, fill slot, LRU victim and rank update
   always_comb begin
      hit_any   = 1'b0;
      hit_w     = '0;
      emp_found = 1'b0;
      emp_w     = '0;
      vic_w     = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         vld[w]   = rv_rd_ff & row_rd_ff[w*ENT_W + AB + RK_W];
         rk[w]    = row_rd_ff[w*ENT_W + AB +: RK_W];
         tg[w]    = row_rd_ff[w*ENT_W +: AB];
         act[w]   = (WI_W'(w) <= wm1_ff);
         match[w] = act[w] & vld[w] & (tg[w] == tag_ff);
         if (match[w]) begin
            hit_any = 1'b1;
            hit_w   = WI_W'(w);
         end
      end
      home = tag_ff[WI_W-1:0] & wm1_ff;
      for (int i = 0; i < MAX_WAYS; i++) begin
         w_i = (home + WI_W'(i)) & wm1_ff;
         if (!emp_found && !vld[w_i]) begin
            emp_found = 1'b1;
            emp_w     = w_i;
         end
      end
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (act[i] && (rk[i] > rk[vic_w])) begin
            vic_w = WI_W'(i);
         end
      end
      priority if (hit_any) begin
         u_w = hit_w;
         old = {1'b0, rk[hit_w]};
      end else if (emp_found) begin
         u_w = emp_w;
         old = ways_ff;
      end else begin
         u_w = vic_w;
         old = {1'b0, rk[vic_w]};
      end
      upd = !hit_any || touch_ff;
      for (int v = 0; v < MAX_WAYS; v++) begin
         nvl = vld[v];
         nrk = rk[v];
         ntg = tg[v];
         if (WI_W'(v) == u_w) begin
            nvl = 1'b1;
            nrk = '0;
            if (!hit_any) begin
               ntg = tag_ff;
            end
         end else if (act[v] && vld[v] && ({1'b0, rk[v]} < old)) begin
            nrk = rk[v] + RK_W'(1);
         end
         new_row[v*ENT_W +: ENT_W] = {nvl, nrk, ntg};
      end
   end

   assign hit = hit_any;

   // row write-back
   always_ff @(posedge clock) begin
      if (phase_ff && upd) begin
         rows_ff[set_ff] <= new_row;
      end
   end

   // per-set valid flags, cleared on reset and geometry change
   always_ff @(posedge clock) begin
      if (reset || flush) begin
         rowv_ff <= '0;
      end else if (phase_ff && upd) begin
         rowv_ff[set_ff] <= 1'b1;
      end
   end
endmodule

/* design/two_level_lru_cache_tags_prefetch.sv */
// Two-level tag directory with true LRU and next-block prefetch into L2.
// An item is taken when start is high and busy is low; its one result
// appears on the rsp_ ports for a single cycle with rsp_valid and must be
// taken then, since the receiver cannot hold it off. Each directory lookup
// is a read of one set row followed by a write-back cycle, and lookups run
// one after another: L1, then L2 on an L1 miss, then the prefetch lookup
// in L2 on an L2 miss with prefetch enabled; busy drops in the result
// cycle so the next item can be taken there. A write to any geometry
// register invalidates both directories.
`include "two_level_lru_cache_tags_prefetch_defines.svh"
module two_level_lru_cache_tags_prefetch import tlc_pkg::*; #(
   parameter int ADDRESS_BITS = ADDRESS_BITS_DEF,
   parameter int L1_MAX_SETS  = L1_MAX_SETS_DEF,
   parameter int L1_MAX_WAYS  = L1_MAX_WAYS_DEF,
   parameter int L2_MAX_SETS  = L2_MAX_SETS_DEF,
   parameter int L2_MAX_WAYS  = L2_MAX_WAYS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_command,
   input  logic [ADDRESS_BITS-1:0] req_address,
   output logic                    rsp_valid,
   output logic                    rsp_l1_hit,
   output logic                    rsp_l2_looked_up,
   output logic                    rsp_l2_hit,
   output logic [1:0]              rsp_memory_reads,
   output logic                    rsp_memory_write,
   output logic                    rsp_prefetch_done,
   output logic                    rsp_prefetch_was_present,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DAT_W-1:0]    csr_write_data
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_L1   = 3'd1;
   localparam logic [2:0] S_L1W  = 3'd2;
   localparam logic [2:0] S_L2   = 3'd3;
   localparam logic [2:0] S_L2W  = 3'd4;
   localparam logic [2:0] S_PF   = 3'd5;
   localparam logic [2:0] S_PFW  = 3'd6;

   logic [OFFSET_W-1:0] l1_ob_ff, l2_ob_ff;
   logic [L1_SET_W-1:0] l1_sb_ff;
   logic [L2_SET_W-1:0] l2_sb_ff;
   logic [WAYS_W-1:0]   l1_wl_ff, l2_wl_ff;
   logic                pf_en_ff;
   logic                flush;

   // configuration registers
   assign flush = csr_write_enable && (csr_index != CSR_PREFETCH) &&
                  (csr_index <= CSR_L2_WAYS);

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_ob_ff <= L1_OFFSET_RST;
         l1_sb_ff <= L1_SETS_RST;
         l1_wl_ff <= L1_WAYS_RST;
         l2_ob_ff <= L2_OFFSET_RST;
         l2_sb_ff <= L2_SETS_RST;
         l2_wl_ff <= L2_WAYS_RST;
         pf_en_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_L1_OFFSET: l1_ob_ff <= csr_write_data[OFFSET_W-1:0];
            CSR_L1_SETS:   l1_sb_ff <= csr_write_data[L1_SET_W-1:0];
            CSR_L1_WAYS:   l1_wl_ff <= csr_write_data[WAYS_W-1:0];
            CSR_L2_OFFSET: l2_ob_ff <= csr_write_data[OFFSET_W-1:0];
            CSR_L2_SETS:   l2_sb_ff <= csr_write_data[L2_SET_W-1:0];
            CSR_L2_WAYS:   l2_wl_ff <= csr_write_data[WAYS_W-1:0];
            CSR_PREFETCH:  pf_en_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   logic [2:0]              state_ff, state_in;
   logic                    cmd_ff;
   logic [ADDRESS_BITS-1:0] addr_ff, next_ff;
   logic                    l1_hit, l2_hit;
   logic                    l1_go, l2_go;
   logic [ADDRESS_BITS-1:0] l2_addr;

   assign busy    = (state_ff != S_IDLE);
   assign l1_go   = (state_ff == S_L1);
   assign l2_go   = (state_ff == S_L2) || (state_ff == S_PF);
   assign l2_addr = (state_ff == S_PF) ? next_ff : addr_ff;

   tlc_dir #(
      .AB(ADDRESS_BITS), .MAX_SETS(L1_MAX_SETS), .MAX_WAYS(L1_MAX_WAYS),
      .SET_CFG_W(L1_SET_W)
   ) u_l1 (
      .clock(clock), .reset(reset), .flush(flush), .go(l1_go), .touch(1'b1),
      .address(addr_ff), .offset_bits(l1_ob_ff), .set_bits(l1_sb_ff),
      .ways_log2(l1_wl_ff), .hit(l1_hit)
   );

   tlc_dir #(
      .AB(ADDRESS_BITS), .MAX_SETS(L2_MAX_SETS), .MAX_WAYS(L2_MAX_WAYS),
      .SET_CFG_W(L2_SET_W)
   ) u_l2 (
      .clock(clock), .reset(reset), .flush(flush), .go(l2_go),
      .touch(state_ff == S_L2), .address(l2_addr), .offset_bits(l2_ob_ff),
      .set_bits(l2_sb_ff), .ways_log2(l2_wl_ff), .hit(l2_hit)
   );

   logic       fin;
   logic       r_l1h, r_l2l, r_l2h, r_pf, r_pfp;
   logic [1:0] r_reads;

   // sequencer
   always_comb begin
      state_in = state_ff;
      fin      = 1'b0;
      r_l1h    = 1'b0;
      r_l2l    = 1'b0;
      r_l2h    = 1'b0;
      r_pf     = 1'b0;
      r_pfp    = 1'b0;
      r_reads  = 2'd0;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_L1;
         S_L1:   state_in = S_L1W;
         S_L1W: begin
            if (l1_hit) begin
               fin      = 1'b1;
               r_l1h    = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_L2;
            end
         end
         S_L2:   state_in = S_L2W;
         S_L2W: begin
            r_l2l = 1'b1;
            r_l2h = l2_hit;
            if (l2_hit) begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end else if (pf_en_ff) begin
               state_in = S_PF;
            end else begin
               fin      = 1'b1;
               r_reads  = 2'd1;
               state_in = S_IDLE;
            end
         end
         S_PF:   state_in = S_PFW;
         S_PFW: begin
            fin      = 1'b1;
            r_l2l    = 1'b1;
            r_pf     = 1'b1;
            r_pfp    = l2_hit;
            r_reads  = l2_hit ? 2'd1 : 2'd2;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= fin;
      end
   end

   // item capture, prefetch address, result register
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         cmd_ff  <= req_command;
         addr_ff <= req_address;
      end
      if (state_ff == S_L2W) begin
         next_ff <= addr_ff + (ADDRESS_BITS'(1) << l2_ob_ff);
      end
      if (fin) begin
         rsp_l1_hit               <= r_l1h;
         rsp_l2_looked_up         <= r_l2l;
         rsp_l2_hit               <= r_l2h;
         rsp_memory_reads         <= r_reads;
         rsp_memory_write         <= cmd_ff;
         rsp_prefetch_done        <= r_pf;
         rsp_prefetch_was_present <= r_pfp;
      end
   end

   `TLC_ASSERT_NOW(a_hit_excl, clock, reset, rsp_valid, !(rsp_l1_hit && rsp_l2_looked_up))
   `TLC_ASSERT_NOW(a_l2_hit_needs_lookup, clock, reset, rsp_valid && rsp_l2_hit, rsp_l2_looked_up)
   `TLC_ASSERT_NOW(a_pf_present, clock, reset, rsp_valid && rsp_prefetch_was_present, rsp_prefetch_done)
   `TLC_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy)
endmodule

/* sim/tb_two_level_lru_cache_tags_prefetch.sv */
`timescale 1ns / 1ps
module tb_two_level_lru_cache_tags_prefetch;
   import tlc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_DRAIN  = 10;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_command;
   logic [47:0]          req_address;
   logic                 rsp_valid;
   logic                 rsp_l1_hit;
   logic                 rsp_l2_looked_up;
   logic                 rsp_l2_hit;
   logic [1:0]           rsp_memory_reads;
   logic                 rsp_memory_write;
   logic                 rsp_prefetch_done;
   logic                 rsp_prefetch_was_present;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_write_data;

   typedef struct packed {
      logic       l1_hit;
      logic       l2_looked_up;
      logic       l2_hit;
      logic [1:0] memory_reads;
      logic       memory_write;
      logic       prefetch_done;
      logic       prefetch_was_present;
   } access_outcome_type;

   access_outcome_type pending_outcomes[$];
   int              mismatch_count;
   int              outcome_count;
   int              item_count;
   int              cycle_count;

   // directory shadow: index 0 is L1, index 1 is L2; both hold 8 ways per set
   logic        dir_valid [2][2048];
   logic [47:0] dir_tag   [2][2048];
   int          dir_rank  [2][2048];
   int          dir_fill  [2][256];

   // shadow of the configuration registers
   int cfg_l1_offset, cfg_l1_sets, cfg_l1_ways;
   int cfg_l2_offset, cfg_l2_sets, cfg_l2_ways;
   int cfg_prefetch;

   two_level_lru_cache_tags_prefetch u_top (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_command             (req_command),
      .req_address             (req_address),
      .rsp_valid               (rsp_valid),
      .rsp_l1_hit              (rsp_l1_hit),
      .rsp_l2_looked_up        (rsp_l2_looked_up),
      .rsp_l2_hit              (rsp_l2_hit),
      .rsp_memory_reads        (rsp_memory_reads),
      .rsp_memory_write        (rsp_memory_write),
      .rsp_prefetch_done       (rsp_prefetch_done),
      .rsp_prefetch_was_present(rsp_prefetch_was_present),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // invalidate both directories
   function automatic void invalidate_all();
      for (int l = 0; l < 2; l++) begin
         for (int i = 0; i < 2048; i++) dir_valid[l][i] = 1'b0;
         for (int s = 0; s < 256; s++) dir_fill[l][s] = 0;
      end
   endfunction

   function automatic int shrink_bits(int bits, int limit);
      int b;
      b = bits;
      while (b > 0 && (1 << b) > limit) b--;
      return b;
   endfunction

   // make way u most recent, aging the ways younger than its old rank
   function automatic void promote_way(int lv, int base, int ways, int u, int old);
      for (int v = 0; v < ways; v++)
         if (v != u && dir_valid[lv][base+v] && dir_rank[lv][base+v] < old)
            dir_rank[lv][base+v]++;
      dir_rank[lv][base+u] = 0;
   endfunction

   // one tag lookup with allocate on miss; returns the hit flag
   function automatic bit lookup_block(int lv, logic [47:0] addr, int ob, int sbits,
                                       int wbits, bit promote_on_hit);
      int          sb, ways, set_idx, base, home, w, victim;
      logic [47:0] tag;
      sb      = shrink_bits(sbits, lv ? 256 : 64);
      ways    = 1 << shrink_bits(wbits, 8);
      set_idx = int'((addr >> ob) & ((48'd1 << sb) - 48'd1));
      tag     = addr >> (ob + sb);
      base    = set_idx * 8;
      home    = int'(tag % ways);
      for (int i = 0; i < ways; i++) begin
         w = (home + i) % ways;
         if (dir_valid[lv][base+w] && dir_tag[lv][base+w] == tag) begin
            if (promote_on_hit) promote_way(lv, base, ways, w, dir_rank[lv][base+w]);
            return 1'b1;
         end
      end
      for (int i = 0; i < ways; i++) begin
         w = (home + i) % ways;
         if (!dir_valid[lv][base+w]) begin
            dir_valid[lv][base+w] = 1'b1;
            dir_tag[lv][base+w]   = tag;
            if (dir_fill[lv][set_idx] < ways) dir_fill[lv][set_idx]++;
            promote_way(lv, base, ways, w, ways);
            return 1'b0;
         end
      end
      victim = 0;
      for (int i = 1; i < ways; i++)
         if (dir_rank[lv][base+i] > dir_rank[lv][base+victim]) victim = i;
      dir_tag[lv][base+victim] = tag;
      promote_way(lv, base, ways, victim, dir_rank[lv][base+victim]);
      return 1'b0;
   endfunction

   // expected outcome of one access, updating the shadow directories
   function automatic access_outcome_type predict_access(logic cmd, logic [47:0] addr);
      access_outcome_type o;
      logic [47:0]     next_addr;
      o = '0;
      o.memory_write = cmd;
      o.l1_hit = lookup_block(0, addr, cfg_l1_offset, cfg_l1_sets, cfg_l1_ways, 1'b1);
      if (!o.l1_hit) begin
         o.l2_looked_up = 1'b1;
         o.l2_hit = lookup_block(1, addr, cfg_l2_offset, cfg_l2_sets, cfg_l2_ways, 1'b1);
         if (!o.l2_hit) begin
            o.memory_reads = 2'd1;
            if (cfg_prefetch != 0) begin
               next_addr = addr + (48'd1 << cfg_l2_offset);
               o.prefetch_done = 1'b1;
               o.prefetch_was_present = lookup_block(1, next_addr, cfg_l2_offset,
                                                     cfg_l2_sets, cfg_l2_ways, 1'b0);
               if (!o.prefetch_was_present) o.memory_reads = 2'd2;
            end
         end
      end
      return o;
   endfunction

   // send one item; start stays high on return so a zero gap needs no toggle
   task automatic send_access(logic cmd, logic [47:0] addr);
      int  gap;
      bit  taken;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 9) < 3) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      pending_outcomes.push_back(predict_access(cmd, addr));
      item_count++;
      @(negedge clock);
   endtask

   // wait until the block is idle, then write one register
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] value);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (IDLE_DRAIN) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_L1_OFFSET: begin cfg_l1_offset = value & 31; invalidate_all(); end
         CSR_L1_SETS:   begin cfg_l1_sets   = value & 7;  invalidate_all(); end
         CSR_L1_WAYS:   begin cfg_l1_ways   = value & 3;  invalidate_all(); end
         CSR_L2_OFFSET: begin cfg_l2_offset = value & 31; invalidate_all(); end
         CSR_L2_SETS:   begin cfg_l2_sets   = value & 15; invalidate_all(); end
         CSR_L2_WAYS:   begin cfg_l2_ways   = value & 3;  invalidate_all(); end
         CSR_PREFETCH:  cfg_prefetch = value & 1;
         default: ;
      endcase
   endtask

   task automatic set_geometry(int l1o, int l1s, int l1w, int l2o, int l2s, int l2w, int pf);
      write_csr(CSR_L1_OFFSET, CSR_DAT_W'(l1o));
      write_csr(CSR_L1_SETS,   CSR_DAT_W'(l1s));
      write_csr(CSR_L1_WAYS,   CSR_DAT_W'(l1w));
      write_csr(CSR_L2_OFFSET, CSR_DAT_W'(l2o));
      write_csr(CSR_L2_SETS,   CSR_DAT_W'(l2s));
      write_csr(CSR_L2_WAYS,   CSR_DAT_W'(l2w));
      write_csr(CSR_PREFETCH,  CSR_DAT_W'(pf));
   endtask

   function automatic logic [47:0] random_address();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // reset geometry: extremes of the address, hits and misses, both commands
   task automatic test_reset_geometry();
      send_access(1'b0, 48'h0);
      send_access(1'b0, 48'h0);
      send_access(1'b1, 48'hFFFF_FFFF_FFFF);
      send_access(1'b1, 48'hFFFF_FFFF_FFFF);
      send_access(1'b0, 48'h0000_0000_1000);
      send_access(1'b0, 48'h0);
      send_access(1'b1, 48'hAAAA_AAAA_AAAA);
      send_access(1'b0, 48'h5555_5555_5555);
   endtask

   // prefetch, including the next block wrapping past the top address
   task automatic test_prefetch_wrap();
      write_csr(CSR_PREFETCH, 5'd1);
      send_access(1'b0, 48'hFFFF_FFFF_FFC0);
      send_access(1'b0, 48'h0);
      send_access(1'b1, 48'h0000_0000_0040);
      send_access(1'b0, 48'h0000_0000_0100);
      send_access(1'b0, 48'h0000_0000_0140);
   endtask

   // oversized set and way fields, widest and zero offsets, unused register index
   task automatic test_geometry_extremes();
      set_geometry(31, 15, 3, 31, 31, 3, 31);
      write_csr(3'd7, 5'd31);
      send_access(1'b0, 48'hFFFF_FFFF_FFFF);
      send_access(1'b0, 48'h7FFF_FFFF_FFFF);
      send_access(1'b1, 48'h0);
      set_geometry(0, 0, 0, 0, 0, 0, 1);
      send_access(1'b0, 48'h3);
      send_access(1'b0, 48'h3);
      send_access(1'b1, 48'h4);
      send_access(1'b0, 48'hFFFF_FFFF_FFFF);
      send_access(1'b0, 48'h3);
   endtask

   // random geometry per phase; most addresses reuse a small working set
   task automatic test_random_phases();
      logic [47:0] hot [16];
      logic [47:0] addr;
      int          pick;
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 0) set_geometry(6, 6, 0, 6, 8, 2, 0);
         else if (phase == 1) set_geometry(2, 1, 3, 3, 2, 3, 1);
         else set_geometry($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                           $urandom_range(0, 31));
         for (int i = 0; i < 16; i++) hot[i] = random_address();
         for (int n = 0; n < 140; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) addr = random_address();
            else if (pick < 4) addr = hot[$urandom_range(0, 15)] + 48'($urandom_range(0, 4096));
            else addr = hot[$urandom_range(0, 15)] ^ 48'($urandom_range(0, 255));
            send_access(1'($urandom), addr);
         end
      end
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      access_outcome_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_l1_hit, rsp_l2_looked_up, rsp_l2_hit, rsp_memory_reads,
                rsp_memory_write, rsp_prefetch_done, rsp_prefetch_was_present};
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_outcomes.pop_front();
            outcome_count++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch on result %0d: expected %p, got %p",
                           outcome_count, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_command      = 1'b0;
      req_address      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      mismatch_count   = 0;
      outcome_count    = 0;
      item_count       = 0;
      cycle_count      = 0;
      for (int l = 0; l < 2; l++)
         for (int i = 0; i < 2048; i++) begin
            dir_tag[l][i]  = '0;
            dir_rank[l][i] = 0;
         end
      invalidate_all();
      cfg_l1_offset = 6; cfg_l1_sets = 6; cfg_l1_ways = 0;
      cfg_l2_offset = 6; cfg_l2_sets = 8; cfg_l2_ways = 2;
      cfg_prefetch  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_geometry();
      test_prefetch_wrap();
      test_geometry_extremes();
      test_random_phases();

      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
      repeat (IDLE_DRAIN) @(negedge clock);
      $display("covered %0d accesses and %0d results over directed and random geometries",
               item_count, outcome_count);
      $display("mismatches: %0d", mismatch_count);
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
